// File: design/multi_task_deadline_watchdog_unit_defines.svh
// ----------------------------------------------------------------------------
// Multi-task deadline watchdog assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_TASK_DEADLINE_WATCHDOG_UNIT_DEFINES_SVH
`define MULTI_TASK_DEADLINE_WATCHDOG_UNIT_DEFINES_SVH

// same-cycle implication
`define MTDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTDW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mtdw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-task deadline watchdog package
// Field widths, operation and status codes, register indexes and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mtdw_pkg;

    localparam int OP_W        = 2;
    localparam int TIME_W      = 32;
    localparam int ID_W        = 3;
    localparam int MASK_BITS   = 8;
    localparam int STATUS_W    = 3;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 4;
    localparam int REG_IDX_W   = 2;
    localparam logic [TIME_W-1:0] HW_TIMEOUT_RST = 32'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_REG    = 2'd0,
        OP_KICK   = 2'd1,
        OP_POLL   = 2'd2,
        OP_HWKICK = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_NOT_EN = 3'd1,
        ST_BAD_DL = 3'd2,
        ST_FULL   = 3'd3,
        ST_BAD_ID = 3'd4
    } t_status;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SW_EN      = 2'd0,
        REG_HW_EN      = 2'd1,
        REG_HW_TIMEOUT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_POLL = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef struct packed {
        logic sw_en;
        logic hw_en;
        logic sw_rise;
        logic hw_rise;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic poll_op;
        logic poll_done;
        logic out_busy;
    } t_dp_sts;

endpackage

// File: design/mtdw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-task deadline watchdog channels
// Request channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface mtdw_req_if;
    import mtdw_pkg::*;

    logic              valid;
    logic              ready;
    t_op               op;
    logic [TIME_W-1:0] now_ms;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] due_ms;

    modport source (output valid, op, now_ms, task_id, due_ms, input ready);
    modport sink   (input valid, op, now_ms, task_id, due_ms, output ready);
endinterface

interface mtdw_rsp_if;
    import mtdw_pkg::*;

    logic                 valid;
    logic                 ready;
    t_status              status;
    logic [ID_W-1:0]      assigned_id;
    logic [MASK_BITS-1:0] expired_mask;
    logic [MASK_BITS-1:0] newly_expired;
    logic                 overdue_any;
    logic                 hw_kick_pulse;
    logic                 hw_kick_allowed;

    modport source (output valid, status, assigned_id, expired_mask, newly_expired,
                    overdue_any, hw_kick_pulse, hw_kick_allowed, input ready);
    modport sink   (input valid, status, assigned_id, expired_mask, newly_expired,
                    overdue_any, hw_kick_pulse, hw_kick_allowed, output ready);
endinterface

// File: design/mtdw_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-task deadline watchdog configuration registers
// APB-style register file with enable edge detection.
// ----------------------------------------------------------------------------
module mtdw_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mtdw_pkg::ADDR_W-1:0] paddr,
    input  logic [mtdw_pkg::DATA_W-1:0] pwdata,
    output logic [mtdw_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output mtdw_pkg::t_cfg              o_cfg
);
    import mtdw_pkg::*;

    logic              r_sw_en;
    logic              r_hw_en;
    logic [TIME_W-1:0] r_hw_timeout;
    logic              w_wr;
    t_reg_idx          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_en      <= 1'b0;
            r_hw_en      <= 1'b0;
            r_hw_timeout <= HW_TIMEOUT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SW_EN:      r_sw_en      <= pwdata[0];
                REG_HW_EN:      r_hw_en      <= pwdata[0];
                REG_HW_TIMEOUT: r_hw_timeout <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SW_EN:      prdata = DATA_W'(r_sw_en);
            REG_HW_EN:      prdata = DATA_W'(r_hw_en);
            REG_HW_TIMEOUT: prdata = DATA_W'(r_hw_timeout);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.sw_en   = r_sw_en;
        o_cfg.hw_en   = r_hw_en;
        o_cfg.sw_rise = w_wr && (w_idx == REG_SW_EN) && pwdata[0] && !r_sw_en;
        o_cfg.hw_rise = w_wr && (w_idx == REG_HW_EN) && pwdata[0] && !r_hw_en;
    end

endmodule

// File: design/mtdw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-task deadline watchdog controller
// Sequences request capture, the slot poll walk and result commit.
// ----------------------------------------------------------------------------
module mtdw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mtdw_pkg::t_dp_sts i_sts,
    output mtdw_pkg::t_dp_cmd o_cmd
);
    import mtdw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.poll_op) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_POLL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POLL: begin
                if (i_sts.poll_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: design/mtdw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-task deadline watchdog datapath
// Slot tables, poll compare pipeline, task state and result register.
// ----------------------------------------------------------------------------
module mtdw_dp #(
    parameter int MAX_TASKS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mtdw_pkg::t_dp_cmd              i_cmd,
    output mtdw_pkg::t_dp_sts              o_sts,
    input  mtdw_pkg::t_cfg                 i_cfg,
    input  mtdw_pkg::t_op                  i_op,
    input  logic [mtdw_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [mtdw_pkg::ID_W-1:0]      i_task_id,
    input  logic [mtdw_pkg::TIME_W-1:0]    i_due_ms,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output mtdw_pkg::t_status              o_status,
    output logic [mtdw_pkg::ID_W-1:0]      o_assigned_id,
    output logic [mtdw_pkg::MASK_BITS-1:0] o_expired_mask,
    output logic [mtdw_pkg::MASK_BITS-1:0] o_newly_expired,
    output logic                           o_overdue_any,
    output logic                           o_hw_kick_pulse,
    output logic                           o_hw_kick_allowed
);
    import mtdw_pkg::*;

    localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int CMP_W  = CNT_W + ID_W;
    localparam int EXT_W  = (MAX_TASKS > MASK_BITS) ? MAX_TASKS : MASK_BITS;

    logic [TIME_W-1:0]    r_dl_mem [MAX_TASKS];
    logic [TIME_W-1:0]    r_lk_mem [MAX_TASKS];

    t_op                  r_op;
    logic [TIME_W-1:0]    r_now;
    logic [ID_W-1:0]      r_id;
    logic [TIME_W-1:0]    r_dl;

    logic [MAX_TASKS-1:0] r_expired;
    logic [CNT_W-1:0]     r_used;
    logic                 r_kick_perm;

    logic [CNT_W-1:0]     r_idx;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [TIME_W-1:0]    r_rd_dl;
    logic [TIME_W-1:0]    r_rd_lk;
    logic                 r_any;
    logic [MAX_TASKS-1:0] r_newly;

    logic                 r_out_vld;
    t_status              r_out_status;
    logic [ID_W-1:0]      r_out_assigned;
    logic [MASK_BITS-1:0] r_out_exp;
    logic [MASK_BITS-1:0] r_out_newly;
    logic                 r_out_any;
    logic                 r_out_pulse;
    logic                 r_out_allowed;

    logic                 w_issue;
    logic [TIME_W-1:0]    w_elapsed;
    logic                 w_overdue;
    logic [IDX_W-1:0]     w_slot;
    logic [IDX_W-1:0]     w_kslot;
    logic                 w_full;
    logic                 w_bad_id;
    logic                 w_reg_ok;
    logic                 w_kick_ok;
    logic [IDX_W-1:0]     w_wr_addr;

    t_status              n_status;
    logic [ID_W-1:0]      n_assigned;
    logic [MAX_TASKS-1:0] n_exp;
    logic [MAX_TASKS-1:0] n_newly;
    logic                 n_any;
    logic                 n_perm;
    logic                 n_pulse;
    logic [CNT_W-1:0]     n_used;
    logic [EXT_W-1:0]     w_exp_ext;
    logic [EXT_W-1:0]     w_newly_ext;

    assign w_issue   = i_cmd.step && (r_idx < r_used);
    assign w_elapsed = r_now - r_rd_lk;
    assign w_overdue = (r_now >= r_rd_lk) && (w_elapsed > r_rd_dl);

    assign w_slot    = r_used[IDX_W-1:0];
    assign w_kslot   = IDX_W'(r_id);
    assign w_full    = r_used >= CNT_W'(MAX_TASKS);
    assign w_bad_id  = CMP_W'(r_id) >= CMP_W'(r_used);

    always_comb begin
        n_status   = ST_OK;
        n_assigned = '0;
        n_exp      = r_expired;
        n_newly    = '0;
        n_any      = 1'b0;
        n_perm     = r_kick_perm;
        n_pulse    = 1'b0;
        w_reg_ok   = 1'b0;
        w_kick_ok  = 1'b0;
        unique case (r_op)
            OP_REG: begin
                if (!i_cfg.sw_en) begin
                    n_status = ST_NOT_EN;
                end else if (r_dl == '0) begin
                    n_status = ST_BAD_DL;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_reg_ok      = 1'b1;
                    n_assigned    = ID_W'(r_used);
                    n_exp[w_slot] = 1'b0;
                end
            end
            OP_KICK: begin
                if (!i_cfg.sw_en) begin
                    n_status = ST_NOT_EN;
                end else if (w_bad_id) begin
                    n_status = ST_BAD_ID;
                end else begin
                    w_kick_ok      = 1'b1;
                    n_exp[w_kslot] = 1'b0;
                end
            end
            OP_POLL: begin
                if (!i_cfg.sw_en) begin
                    n_status = ST_NOT_EN;
                end else begin
                    n_exp   = r_expired | r_newly;
                    n_newly = r_newly;
                    n_any   = r_any;
                    if (r_any) begin
                        n_perm = 1'b0;
                    end
                end
            end
            OP_HWKICK: n_pulse = i_cfg.hw_en && r_kick_perm;
            default: ;
        endcase
    end

    assign n_used      = w_reg_ok ? r_used + CNT_W'(1) : r_used;
    assign w_wr_addr   = w_reg_ok ? w_slot : w_kslot;
    assign w_exp_ext   = EXT_W'(n_exp);
    assign w_newly_ext = EXT_W'(n_newly);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_now <= i_now_ms;
            r_id  <= i_task_id;
            r_dl  <= i_due_ms;
        end
        if (i_cmd.commit && w_reg_ok) begin
            r_dl_mem[w_wr_addr] <= r_dl;
        end
        if (i_cmd.commit && (w_reg_ok || w_kick_ok)) begin
            r_lk_mem[w_wr_addr] <= r_now;
        end
        if (w_issue) begin
            r_rd_idx <= r_idx[IDX_W-1:0];
            r_rd_dl  <= r_dl_mem[r_idx[IDX_W-1:0]];
            r_rd_lk  <= r_lk_mem[r_idx[IDX_W-1:0]];
        end
        if (i_cmd.commit) begin
            r_out_status   <= n_status;
            r_out_assigned <= n_assigned;
            r_out_exp      <= w_exp_ext[MASK_BITS-1:0];
            r_out_newly    <= w_newly_ext[MASK_BITS-1:0];
            r_out_any      <= n_any;
            r_out_pulse    <= n_pulse;
            r_out_allowed  <= n_perm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expired   <= '0;
            r_used      <= '0;
            r_kick_perm <= 1'b1;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_any       <= 1'b0;
            r_newly     <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_any   <= 1'b0;
                r_newly <= '0;
            end else if (w_issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            r_rd_vld <= w_issue;
            if (r_rd_vld && w_overdue) begin
                r_any <= 1'b1;
                if (!r_expired[r_rd_idx]) begin
                    r_newly[r_rd_idx] <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_used      <= n_used;
                r_expired   <= n_exp;
                r_kick_perm <= n_perm;
                r_out_vld   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg.sw_rise) begin
                r_used    <= '0;
                r_expired <= '0;
            end
            if (i_cfg.hw_rise) begin
                r_kick_perm <= 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.poll_op   = (r_op == OP_POLL) && i_cfg.sw_en;
        o_sts.poll_done = (r_idx >= r_used) && !r_rd_vld;
        o_sts.out_busy  = r_out_vld && !i_out_ready;
    end

    assign o_out_valid       = r_out_vld;
    assign o_status          = r_out_status;
    assign o_assigned_id     = r_out_assigned;
    assign o_expired_mask    = r_out_exp;
    assign o_newly_expired   = r_out_newly;
    assign o_overdue_any     = r_out_any;
    assign o_hw_kick_pulse   = r_out_pulse;
    assign o_hw_kick_allowed = r_out_allowed;

endmodule

// File: design/multi_task_deadline_watchdog_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-task deadline watchdog
// Supervises software task deadlines and gates hardware watchdog kicks.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: op, now_ms, task_id, due_ms. o_rsp returns
//   exactly one result per request. Registers sit on the APB-style port:
//   sw_enable at 0x0, hw_enable at 0x4, the hardware timeout at 0x8; write
//   only while no request is in flight.
//   Register, kick and hardware kick requests go from accept through the
//   execute and done states to the result register. A poll also walks the N
//   registered slots, N being the number of registered slots: the walk reads
//   one slot per cycle from the slot tables and compares it in the next.
//   i_req.ready is high only while no request is in flight; a finished result
//   waits in the output register, so the next request is taken while the
//   receiver stalls. A new result is held back until the previous one has
//   been taken.
//   Reset empties the task table, clears all expired marks, permits hardware
//   kicks and returns both enables to off with a 1000 ms timeout.
// ----------------------------------------------------------------------------
module multi_task_deadline_watchdog_unit #(
    parameter int MAX_TASKS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mtdw_pkg::ADDR_W-1:0] paddr,
    input  logic [mtdw_pkg::DATA_W-1:0] pwdata,
    output logic [mtdw_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    mtdw_req_if.sink                    i_req,
    mtdw_rsp_if.source                  o_rsp
);
    import mtdw_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    mtdw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mtdw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_req.ready = w_in_ready;

    mtdw_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg             (w_cfg),
        .i_op              (i_req.op),
        .i_now_ms          (i_req.now_ms),
        .i_task_id         (i_req.task_id),
        .i_due_ms          (i_req.due_ms),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_status          (o_rsp.status),
        .o_assigned_id     (o_rsp.assigned_id),
        .o_expired_mask    (o_rsp.expired_mask),
        .o_newly_expired   (o_rsp.newly_expired),
        .o_overdue_any     (o_rsp.overdue_any),
        .o_hw_kick_pulse   (o_rsp.hw_kick_pulse),
        .o_hw_kick_allowed (o_rsp.hw_kick_allowed)
    );

endmodule

// File: design/mtdw_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-task deadline watchdog port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_task_deadline_watchdog_unit_defines.svh"

module mtdw_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [mtdw_pkg::STATUS_W-1:0]  i_status,
    input logic [mtdw_pkg::MASK_BITS-1:0] i_expired_mask,
    input logic [mtdw_pkg::MASK_BITS-1:0] i_newly_expired,
    input logic                           i_overdue_any,
    input logic                           i_hw_kick_pulse,
    input logic                           i_hw_kick_allowed
);
    import mtdw_pkg::*;

    `MTDW_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request accepted while previous one in flight")
    `MTDW_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_expired_mask), "stalled result changed")
    `MTDW_ASSERT_IMP(a_pulse_allowed, i_clk, i_rst_n, i_out_valid && i_hw_kick_pulse, i_hw_kick_allowed, "kick pulse without permission")
    `MTDW_ASSERT_IMP(a_newly_in_mask, i_clk, i_rst_n, i_out_valid, (i_newly_expired & ~i_expired_mask) == '0, "newly expired slot missing from mask")
    `MTDW_ASSERT_IMP(a_newly_needs_any, i_clk, i_rst_n, i_out_valid && !i_overdue_any, i_newly_expired == '0, "newly expired without any overdue slot")

endmodule

bind multi_task_deadline_watchdog_unit mtdw_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_status          (o_rsp.status),
    .i_expired_mask    (o_rsp.expired_mask),
    .i_newly_expired   (o_rsp.newly_expired),
    .i_overdue_any     (o_rsp.overdue_any),
    .i_hw_kick_pulse   (o_rsp.hw_kick_pulse),
    .i_hw_kick_allowed (o_rsp.hw_kick_allowed)
);
